/* rtl/accel_gesture_classifier_assert.svh */
// ----------------------------------------------------------------------------
// Gesture classifier assertion macros
// Concurrent assertion wrappers on clock, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ACCEL_GESTURE_CLASSIFIER_ASSERT_SVH
`define ACCEL_GESTURE_CLASSIFIER_ASSERT_SVH

// masked while reset is high
`define AGC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked through reset as well
`define AGC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/agc_pkg.sv */
// ----------------------------------------------------------------------------
// Gesture classifier package
// Widths, reset values, codes and types shared by the classifier files.
// ----------------------------------------------------------------------------
package agc_pkg;

   // sample arithmetic
   localparam int ACCEL_W = 16;   // used bits of each axis, 12..16
   localparam int TIME_W  = 32;   // used bits of the timestamp, 16..32

   // register widths
   localparam int HOLD_W  = 16;
   localparam int LEVEL_W = 15;
   localparam int TAN_W   = 16;   // Q16 tangent, all fraction bits
   localparam int ACT_W   = 3;

   // request / response packing
   localparam int NOW_FIELD_W   = 32;
   localparam int ACCEL_FIELD_W = 16;
   localparam int X_LSB         = NOW_FIELD_W;
   localparam int Y_LSB         = X_LSB + ACCEL_FIELD_W;
   localparam int Z_LSB         = Y_LSB + ACCEL_FIELD_W;
   localparam int REQ_DATA_W    = Z_LSB + ACCEL_FIELD_W;
   localparam int RSP_DATA_W    = 8;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SHAKE   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_TAP     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_TAP_Z   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_TANGENT = CSR_IDX_W'(4);

   localparam logic [HOLD_W-1:0]  HOLDOFF_RST = HOLD_W'(500);
   localparam logic [LEVEL_W-1:0] SHAKE_RST   = LEVEL_W'(8192);
   localparam logic [LEVEL_W-1:0] TAP_RST     = LEVEL_W'(6144);
   localparam logic [LEVEL_W-1:0] TAP_Z_RST   = LEVEL_W'(4915);
   localparam logic [TAN_W-1:0]   TANGENT_RST = TAN_W'(17560);

   // shift-add multiplier: multiplicand/accumulator and multiplier widths
   localparam int ACC_W = 2*TAN_W + 2*ACCEL_W;
   localparam int MP_W  = 2*TAN_W;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE,
      ACT_SHAKE,
      ACT_TAP,
      ACT_FORWARD,
      ACT_BACKWARD,
      ACT_LEFT,
      ACT_RIGHT
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

   // multiply passes
   typedef enum logic [2:0] {
      PH_XX,   // x^2
      PH_YY,   // y^2
      PH_ZZ,   // + z^2 -> r2
      PH_SH,   // shake level^2
      PH_TP,   // tap level^2
      PH_TT,   // T^2
      PH_TR,   // T^2 * r2
      PH_TZ    // T * z
   } phase_type;

   typedef struct packed {
      logic x_neg;
      logic x_pos;
      logic y_neg;
      logic y_pos;
      logic z_neg;
      logic z_pos;
      logic z_big;   // |z| > tap z level
   } sign_type;

endpackage

/* rtl/accel_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// Accelerometer gesture classifier
// Shake, tap and four-way tilt detection with a holdoff after each detection.
// Flow: a held-off sample goes straight to the result register; any other
//   sample runs a shift-add multiplier, one multiplier bit per cycle, over up
//   to eight radix-2 passes, and it stops early when the decision comes early.
// Throughput: one sample at a time. A new request is taken only once the last
//   result has left the state machine, and a stalled result waits in the output register while the next sample runs.
// Reset: registers return to defaults and the last detection time to zero.
// ----------------------------------------------------------------------------
module accel_gesture_classifier
   import agc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // action[2:0], zero fill[7:3]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // held_off[0]
   output logic [0:0]            rsp_tuser
);

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;

   logic [HOLD_W-1:0]      holdoff_ff;
   logic [LEVEL_W-1:0]     shake_ff;
   logic [LEVEL_W-1:0]     tap_ff;
   logic [LEVEL_W-1:0]     tapz_ff;
   logic [TAN_W-1:0]       tan_ff;

   logic [TIME_W-1:0]      last_ff, last_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [ACCEL_W-1:0]     ax_ff, ax_in;
   logic [ACCEL_W-1:0]     ay_ff, ay_in;
   logic [ACCEL_W-1:0]     az_ff, az_in;
   sign_type               sign_ff, sign_in;

   logic [ACC_W-1:0]       mc_ff, mc_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [MP_W-1:0]        mp_ff, mp_in;
   logic [2*ACCEL_W-1:0]   x2_ff, x2_in;
   logic [2*ACCEL_W:0]     r2_ff, r2_in;
   logic [2*ACCEL_W+1:0]   m2_ff, m2_in;

   action_type             res_act_ff, res_act_in;
   logic                   res_hold_ff, res_hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   action_type             rsp_act_ff, rsp_act_in;
   logic                   rsp_hold_ff, rsp_hold_in;

   logic [TIME_W-1:0]      req_now;
   logic [TIME_W-1:0]      elapsed;
   logic                   held;
   logic [ACCEL_W-1:0]     req_x, req_y, req_z;
   logic [ACCEL_W-1:0]     mag_x, mag_y, mag_z;
   sign_type               req_sign;

   logic [ACC_W-1:0]       acc_sum;
   logic                   mp_last;
   logic                   lvl_hit;
   logic                   pitch_big;
   logic                   roll_big;

   logic                   load;
   logic                   keep_acc;
   phase_type              load_ph;
   logic                   fin;
   action_type             fin_act;

   // multiplicand for a pass
   function automatic logic [ACC_W-1:0] mc_for(input phase_type ph);
      logic [ACC_W-1:0] v;
      unique case (ph)
         PH_XX: v = ACC_W'(ax_ff);
         PH_YY: v = ACC_W'(ay_ff);
         PH_ZZ: v = ACC_W'(az_ff);
         PH_SH: v = ACC_W'(shake_ff);
         PH_TP: v = ACC_W'(tap_ff);
         PH_TT: v = ACC_W'(tan_ff);
         PH_TR: v = ACC_W'(r2_ff);
         PH_TZ: v = ACC_W'(az_ff);
      endcase
      return v;
   endfunction

   // multiplier for a pass; tt is T^2 as it leaves the accumulator
   function automatic logic [MP_W-1:0] mp_for(input phase_type ph,
                                             input logic [MP_W-1:0] tt);
      logic [MP_W-1:0] v;
      unique case (ph)
         PH_XX: v = MP_W'(ax_ff);
         PH_YY: v = MP_W'(ay_ff);
         PH_ZZ: v = MP_W'(az_ff);
         PH_SH: v = MP_W'(shake_ff);
         PH_TP: v = MP_W'(tap_ff);
         PH_TT: v = MP_W'(tan_ff);
         PH_TR: v = tt;
         PH_TZ: v = MP_W'(tan_ff);
      endcase
      return v;
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_act_ff);
   assign rsp_tuser  = rsp_hold_ff;

   // request decode: signs from bit ACCEL_W-1, magnitudes, holdoff window
   always_comb begin
      req_now = req_tdata[TIME_W-1:0];
      req_x   = req_tdata[X_LSB +: ACCEL_W];
      req_y   = req_tdata[Y_LSB +: ACCEL_W];
      req_z   = req_tdata[Z_LSB +: ACCEL_W];
      mag_x   = req_x[ACCEL_W-1] ? (~req_x + ACCEL_W'(1)) : req_x;
      mag_y   = req_y[ACCEL_W-1] ? (~req_y + ACCEL_W'(1)) : req_y;
      mag_z   = req_z[ACCEL_W-1] ? (~req_z + ACCEL_W'(1)) : req_z;
      elapsed = req_now - last_ff;
      held    = elapsed < TIME_W'(holdoff_ff);
      req_sign.x_neg = req_x[ACCEL_W-1];
      req_sign.x_pos = !req_x[ACCEL_W-1] && (|req_x);
      req_sign.y_neg = req_y[ACCEL_W-1];
      req_sign.y_pos = !req_y[ACCEL_W-1] && (|req_y);
      req_sign.z_neg = req_z[ACCEL_W-1];
      req_sign.z_pos = !req_z[ACCEL_W-1] && (|req_z);
      req_sign.z_big = ACC_W'(mag_z) > ACC_W'(tapz_ff);
   end

   // one multiplier bit per cycle, LSB first
   assign acc_sum   = acc_ff + (mp_ff[0] ? mc_ff : '0);
   assign mp_last   = ~|mp_ff[MP_W-1:1];
   assign lvl_hit   = ACC_W'(m2_ff) > acc_sum;
   assign pitch_big = {x2_ff, {(2*TAN_W){1'b0}}} > acc_sum;
   assign roll_big  = ACC_W'({ay_ff, {TAN_W{1'b0}}}) > acc_sum;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      sign_in      = sign_ff;
      mc_in        = mc_ff;
      acc_in       = acc_ff;
      mp_in        = mp_ff;
      x2_in        = x2_ff;
      r2_in        = r2_ff;
      m2_in        = m2_ff;
      res_act_in   = res_act_ff;
      res_hold_in  = res_hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_act_in   = rsp_act_ff;
      rsp_hold_in  = rsp_hold_ff;
      load         = 1'b0;
      keep_acc     = 1'b0;
      load_ph      = phase_ff;
      fin          = 1'b0;
      fin_act      = ACT_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in  = req_now;
               ax_in   = mag_x;
               ay_in   = mag_y;
               az_in   = mag_z;
               sign_in = req_sign;
               if (held) begin
                  res_act_in  = ACT_NONE;
                  res_hold_in = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_MUL;
                  phase_in = PH_XX;
                  mc_in    = ACC_W'(mag_x);
                  mp_in    = MP_W'(mag_x);
                  acc_in   = '0;
               end
            end
         end

         ST_MUL: begin
            acc_in = acc_sum;
            mc_in  = mc_ff << 1;
            mp_in  = mp_ff >> 1;
            if (mp_last) begin
               unique case (phase_ff)
                  PH_XX: begin
                     x2_in   = acc_sum[2*ACCEL_W-1:0];
                     load    = 1'b1;
                     load_ph = PH_YY;
                  end
                  PH_YY: begin
                     load     = 1'b1;
                     keep_acc = 1'b1;
                     load_ph  = PH_ZZ;
                  end
                  PH_ZZ: begin
                     r2_in    = acc_sum[2*ACCEL_W:0];
                     state_in = ST_SUM;
                  end
                  PH_SH: begin
                     if (lvl_hit) begin
                        fin     = 1'b1;
                        fin_act = ACT_SHAKE;
                     end else begin
                        load    = 1'b1;
                        load_ph = PH_TP;
                     end
                  end
                  PH_TP: begin
                     if (lvl_hit && sign_ff.z_big) begin
                        fin     = 1'b1;
                        fin_act = ACT_TAP;
                     end else begin
                        load    = 1'b1;
                        load_ph = PH_TT;
                     end
                  end
                  PH_TT: begin
                     load    = 1'b1;
                     load_ph = PH_TR;
                  end
                  PH_TR: begin
                     priority if (pitch_big && sign_ff.x_neg) begin
                        fin     = 1'b1;
                        fin_act = ACT_FORWARD;
                     end else if (pitch_big && sign_ff.x_pos) begin
                        fin     = 1'b1;
                        fin_act = ACT_BACKWARD;
                     end else if (sign_ff.y_pos || sign_ff.y_neg) begin
                        // z <= 0 tilts at once; z > 0 needs T*z
                        if (!sign_ff.z_pos) begin
                           fin     = 1'b1;
                           fin_act = sign_ff.y_pos ? ACT_LEFT : ACT_RIGHT;
                        end else begin
                           load    = 1'b1;
                           load_ph = PH_TZ;
                        end
                     end else begin
                        // y zero: roll is 180 degrees when z is negative
                        fin     = 1'b1;
                        fin_act = sign_ff.z_neg ? ACT_LEFT : ACT_NONE;
                     end
                  end
                  PH_TZ: begin
                     fin = 1'b1;
                     if (roll_big) begin
                        fin_act = sign_ff.y_pos ? ACT_LEFT : ACT_RIGHT;
                     end
                  end
               endcase
            end
         end

         ST_SUM: begin
            m2_in    = (2*ACCEL_W+2)'(x2_ff) + (2*ACCEL_W+2)'(r2_ff);
            state_in = ST_MUL;
            load     = 1'b1;
            load_ph  = PH_SH;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = res_act_ff;
               rsp_hold_in  = res_hold_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase

      if (load) begin
         phase_in = load_ph;
         mc_in    = mc_for(load_ph);
         mp_in    = mp_for(load_ph, acc_sum[MP_W-1:0]);
         acc_in   = keep_acc ? acc_sum : '0;
      end

      if (fin) begin
         res_act_in  = fin_act;
         res_hold_in = 1'b0;
         state_in    = ST_DONE;
         if (fin_act != ACT_NONE) begin
            last_in = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holdoff_ff <= HOLDOFF_RST;
         shake_ff   <= SHAKE_RST;
         tap_ff     <= TAP_RST;
         tapz_ff    <= TAP_Z_RST;
         tan_ff     <= TANGENT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_HOLDOFF: holdoff_ff <= csr_data[HOLD_W-1:0];
            REG_SHAKE:   shake_ff   <= csr_data[LEVEL_W-1:0];
            REG_TAP:     tap_ff     <= csr_data[LEVEL_W-1:0];
            REG_TAP_Z:   tapz_ff    <= csr_data[LEVEL_W-1:0];
            REG_TANGENT: tan_ff     <= csr_data[TAN_W-1:0];
            default: ;
         endcase
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      now_ff      <= now_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      sign_ff     <= sign_in;
      mc_ff       <= mc_in;
      acc_ff      <= acc_in;
      mp_ff       <= mp_in;
      x2_ff       <= x2_in;
      r2_ff       <= r2_in;
      m2_ff       <= m2_in;
      res_act_ff  <= res_act_in;
      res_hold_ff <= res_hold_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_hold_ff <= rsp_hold_in;
   end

endmodule

/* rtl/agc_checker.sv */
// ----------------------------------------------------------------------------
// Gesture classifier port checker
// Watches the request and response ports of the classifier over time.
// ----------------------------------------------------------------------------
`include "accel_gesture_classifier_assert.svh"

module agc_checker
   import agc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]            rsp_tuser
);

   `AGC_ASSERT(a_rsp_stall_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")
   `AGC_ASSERT(a_held_no_action, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[ACT_W-1:0] == ACT_NONE, "held-off response carries an action")
   `AGC_ASSERT(a_one_request, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `AGC_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind accel_gesture_classifier agc_checker u_agc_checker (.*);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Gesture classifier testbench
// Sends timestamped three-axis samples through the request stream and checks
// each response (action, held-off flag) against an in-bench model of the
// holdoff window and of the shake / tap / tilt priority. A directed table
// covers the corner cases first. Random samples follow under several
// threshold settings, with random gaps on the request side and back-pressure
// on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   import agc_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int ITEMS_PER_SET = 250;
   localparam int DRAIN_CYCLES  = 200;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      logic [31:0]           now;
      logic [15:0]           ax;
      logic [15:0]           ay;
      logic [15:0]           az;
      logic                  typed;   // expected result given in the row
      action_type            act;
      logic                  held;
   } plan_row_type;

   typedef struct packed {
      action_type act;
      logic       held;
   } gesture_type;

   typedef struct packed {
      logic [15:0] hold;
      logic [15:0] shake;
      logic [15:0] tap;
      logic [15:0] tapz;
      logic [15:0] tan;
   } threshold_set_type;

   localparam int PLAN_ROWS = 29;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // reset defaults: holdoff 500 ms, last detection at 0
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd0,    16'h0,  16'h0, 16'h0, 1'b1, ACT_NONE, 1'b1},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd499,
        16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, ACT_NONE, 1'b1},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd500,  16'h0,  16'h0, 16'h0, 1'b1, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd600,
        16'h8000, 16'h8000, 16'h8000, 1'b1, ACT_SHAKE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd1099,
        16'h7FFF, 16'h0, 16'h0, 1'b1, ACT_NONE, 1'b1},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd1100, 16'h0, 16'h0, 16'd7000,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd1600, -16'sd2000, 16'h0, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd2100, 16'd2000, 16'h0, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd2600, 16'h0, 16'd2000, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd3100, 16'h0, -16'sd2000, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      // roll of 180 degrees
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd3600, 16'h0, 16'h0, -16'sd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd4100, 16'h0, 16'd1, 16'h0,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd4600, 16'h0, 16'hFFFF, 16'hFFFF,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'd5100, 16'd100, 16'd100, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      // holdoff window across the timestamp wrap
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'hFFFF_FF00, 16'h7FFF, 16'h0, 16'h0,
        1'b1, ACT_SHAKE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_00F3, 16'h0, 16'h0, 16'h0,
        1'b1, ACT_NONE, 1'b1},
      // magnitude exactly at a level does not count
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0400, 16'h0, 16'h0, 16'd6144,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0500, 16'h0, 16'h0, -16'sd6145,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0800, 16'd8192, 16'h0, 16'h0,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A00, -16'sd8193, 16'h0, 16'h0,
        1'b0, ACT_NONE, 1'b0},
      // no holdoff, zero tangent: any nonzero pitch or roll tilts
      '{ROW_CSR, REG_HOLDOFF, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0, ACT_NONE, 1'b0},
      '{ROW_CSR, REG_TANGENT, 16'h0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A00, 16'd1, 16'h0, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A00, 16'h0, 16'd1, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A00, 16'h0, 16'h0, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      // tangent 0.5: exact ties on pitch and on roll
      '{ROW_CSR, REG_TANGENT, 16'h8000, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A01, 16'd2048, 16'h0, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A01, 16'h0, 16'd2048, 16'd4096,
        1'b0, ACT_NONE, 1'b0},
      '{ROW_SAMPLE, REG_HOLDOFF, 16'h0, 32'h0000_0A01, 16'h0, -16'sd2049, 16'd4096,
        1'b0, ACT_NONE, 1'b0}
   };

   // hold, shake, tap, tap z, tangent; level bit 15 is dropped by the block
   localparam int NUM_SETS = 8;
   localparam threshold_set_type SETS [NUM_SETS] = '{
      '{16'd500,   16'd8192,  16'd6144,  16'd4915,  16'd17560},
      '{16'd0,     16'd32767, 16'd32767, 16'd32767, 16'd0},
      '{16'd65535, 16'd0,     16'd0,     16'd0,     16'd65535},
      '{16'd100,   16'd12000, 16'd4000,  16'd2000,  16'd32768},
      '{16'd1,     16'hA000,  16'h9800,  16'hFFFF,  16'd1},
      '{16'd250,   16'd20000, 16'd10000, 16'd8000,  16'd65535},
      '{16'd1000,  16'd6000,  16'd6000,  16'd0,     16'd8000},
      '{16'd500,   16'd8192,  16'd6144,  16'd4915,  16'd17560}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;

   // model copy of the thresholds and of the detection timestamp
   logic [HOLD_W-1:0]  hold_ms;
   logic [LEVEL_W-1:0] shake_lvl;
   logic [LEVEL_W-1:0] tap_lvl;
   logic [LEVEL_W-1:0] tapz_lvl;
   logic [TAN_W-1:0]   tan_q16;
   logic [TIME_W-1:0]  last_hit_ms;

   gesture_type gesture_q [$];
   int          idle_pct       = 0;
   int          stall_pct      = 0;
   int          mismatch_count = 0;
   int unsigned cycle_count    = 0;

   accel_gesture_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("accel_gesture_classifier regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // shake, tap, then tilt; squares and cross products kept exact in 64 bits
   function automatic action_type classify_sample(logic [15:0] rx, logic [15:0] ry,
                                                  logic [15:0] rz);
      logic signed [ACCEL_W-1:0] sx;
      logic signed [ACCEL_W-1:0] sy;
      logic signed [ACCEL_W-1:0] sz;
      longint xs;
      longint ys;
      longint zs;
      longint unsigned xx;
      longint unsigned yy;
      longint unsigned zz;
      longint unsigned m2;
      longint unsigned r2;
      longint unsigned t;
      longint unsigned ay;
      longint unsigned az;
      longint unsigned lvl;
      logic pitch_big;
      sx = rx[ACCEL_W-1:0];
      sy = ry[ACCEL_W-1:0];
      sz = rz[ACCEL_W-1:0];
      xs = sx;
      ys = sy;
      zs = sz;
      xx = xs * xs;
      yy = ys * ys;
      zz = zs * zs;
      m2 = xx + yy + zz;
      r2 = yy + zz;
      t  = tan_q16;
      ay = (ys < 0) ? -ys : ys;
      az = (zs < 0) ? -zs : zs;
      lvl = shake_lvl;
      if (m2 > lvl * lvl) return ACT_SHAKE;
      lvl = tap_lvl;
      if (m2 > lvl * lvl && az > longint'(tapz_lvl)) return ACT_TAP;
      pitch_big = (xx << 32) > (t * t) * r2;
      if (xs < 0 && pitch_big) return ACT_FORWARD;
      if (xs > 0 && pitch_big) return ACT_BACKWARD;
      if (ys > 0) begin
         if (zs <= 0 || (ay << 16) > t * az) return ACT_LEFT;
      end else if (ys == 0) begin
         if (zs < 0) return ACT_LEFT;
      end else begin
         if (zs <= 0 || (ay << 16) > t * az) return ACT_RIGHT;
      end
      return ACT_NONE;
   endfunction

   function automatic gesture_type predict_gesture(logic [31:0] now, logic [15:0] rx,
                                                   logic [15:0] ry, logic [15:0] rz);
      gesture_type       res;
      logic [TIME_W-1:0] elapsed;
      elapsed = now[TIME_W-1:0] - last_hit_ms;
      res.held = (elapsed < TIME_W'(hold_ms));
      res.act  = ACT_NONE;
      if (!res.held) begin
         res.act = classify_sample(rx, ry, rz);
         if (res.act != ACT_NONE) last_hit_ms = now[TIME_W-1:0];
      end
      return res;
   endfunction

   function automatic logic [15:0] rand_axis(int span);
      logic [15:0] v;
      case ($urandom_range(15))
         0: begin
            case ($urandom_range(4))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               3: v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         end
         1, 2: v = 16'($urandom);
         3: v = '0;
         default: v = 16'($urandom_range(2 * span) - span);
      endcase
      return v;
   endfunction

   // mostly steps around the holdoff window, now and then a jump anywhere
   function automatic logic [31:0] next_time(logic [31:0] cur);
      logic [31:0] h;
      h = 32'(hold_ms);
      case ($urandom_range(19))
         0: return $urandom;
         1: return cur + h - 1;
         2: return cur + h;
         3, 4, 5, 6, 7, 8: return cur + $urandom_range(h);
         17, 18: return cur + $urandom_range(200);
         default: return cur + h + $urandom_range(60);
      endcase
   endfunction

   task automatic send_sample(logic [31:0] now, logic [15:0] rx, logic [15:0] ry,
                              logic [15:0] rz, logic typed, action_type act, logic held);
      gesture_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rz, ry, rx, now};
      do @(posedge clock); while (!req_tready);
      res = predict_gesture(now, rx, ry, rz);
      if (typed) begin
         res.act  = act;
         res.held = held;
      end
      gesture_q.push_back(res);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_HOLDOFF: hold_ms   = val[HOLD_W-1:0];
         REG_SHAKE:   shake_lvl = val[LEVEL_W-1:0];
         REG_TAP:     tap_lvl   = val[LEVEL_W-1:0];
         REG_TAP_Z:   tapz_lvl  = val[LEVEL_W-1:0];
         REG_TANGENT: tan_q16   = val[TAN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain_samples();
      req_tvalid <= 1'b0;
      while (gesture_q.size() != 0) @(posedge clock);
   endtask

   task automatic apply_thresholds(threshold_set_type ts);
      drain_samples();
      write_csr(REG_HOLDOFF, ts.hold);
      write_csr(REG_SHAKE,   ts.shake);
      write_csr(REG_TAP,     ts.tap);
      write_csr(REG_TAP_Z,   ts.tapz);
      write_csr(REG_TANGENT, ts.tan);
      // unmapped index, must be dropped
      write_csr(REG_TANGENT + CSR_IDX_W'(1 + $urandom_range(2)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      gesture_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (gesture_q.size() == 0) begin
            $error("response with nothing pending: action %0d held_off %0d",
                   rsp_tdata[ACT_W-1:0], rsp_tuser[0]);
            mismatch_count = mismatch_count + 1;
         end else begin
            exp_res = gesture_q.pop_front();
            if (rsp_tdata[ACT_W-1:0] !== exp_res.act) begin
               $error("action: expected %0d, actual %0d", exp_res.act,
                      rsp_tdata[ACT_W-1:0]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tuser[0] !== exp_res.held) begin
               $error("held_off: expected %0d, actual %0d", exp_res.held, rsp_tuser[0]);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_tdata[RSP_DATA_W-1:ACT_W] !== '0) begin
               $error("tdata fill: expected 0, actual %0h", rsp_tdata[RSP_DATA_W-1:ACT_W]);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   initial begin
      logic [31:0] now_cursor;
      int          span;
      hold_ms     = HOLDOFF_RST;
      shake_lvl   = SHAKE_RST;
      tap_lvl     = TAP_RST;
      tapz_lvl    = TAP_Z_RST;
      tan_q16     = TANGENT_RST;
      last_hit_ms = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PLAN_ROWS; k++) begin
         if (PLAN[k].kind == ROW_CSR) begin
            drain_samples();
            write_csr(PLAN[k].index, PLAN[k].value);
            if (k == PLAN_ROWS - 1 || PLAN[k + 1].kind != ROW_CSR) csr_valid <= 1'b0;
         end else begin
            send_sample(PLAN[k].now, PLAN[k].ax, PLAN[k].ay, PLAN[k].az,
                        PLAN[k].typed, PLAN[k].act, PLAN[k].held);
         end
      end

      now_cursor = PLAN[PLAN_ROWS - 1].now;
      for (int s = 0; s < NUM_SETS; s++) begin
         apply_thresholds(SETS[s]);
         for (int i = 0; i < ITEMS_PER_SET; i++) begin
            case ((s + i / 50) % 4)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 56; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 56; end
               default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            case ($urandom_range(3))
               0: span = 2000;
               1: span = 6000;
               2: span = 9000;
               default: span = 16000;
            endcase
            now_cursor = next_time(now_cursor);
            send_sample(now_cursor, rand_axis(span), rand_axis(span), rand_axis(span),
                        1'b0, ACT_NONE, 1'b0);
         end
      end

      drain_samples();
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("accel_gesture_classifier regression: pass");
      else
         $display("accel_gesture_classifier regression: fail");
      $finish;
   end

endmodule
